// File: src/nll_pkg.sv
package nll_pkg;

  localparam int INT_BITS  = 32;
  localparam int EXP_BITS  = 16;
  localparam int INT_OUT_W = 32;
  localparam int SIG_W     = 60;
  localparam int EXP_OUT_W = 16;

  localparam logic [SIG_W-1:0] SIG_MAX = 60'd999999999999999999;

  localparam logic [4:0] RADIX_BIN = 5'd2;
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_HEX = 5'd16;

  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_7     = "7";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LZ    = "z";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UZ    = "Z";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";
  localparam logic [7:0] CH_LB    = "b";
  localparam logic [7:0] CH_UB    = "B";
  localparam logic [7:0] CH_LE    = "e";
  localparam logic [7:0] CH_UE    = "E";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef enum logic [3:0] {
    LEX_IDLE,
    LEX_SIGN,
    LEX_ZERO,
    LEX_RPFX,
    LEX_RDIG,
    LEX_DEC,
    LEX_FRAC0,
    LEX_FRAC,
    LEX_EXP0,
    LEX_EXPS,
    LEX_EXPD
  } lex_state_t;

  typedef enum logic [1:0] {
    KIND_INT,
    KIND_FLOAT,
    KIND_ERR,
    KIND_EOS
  } kind_t;

  typedef struct packed {
    kind_t                        kind;
    logic signed [INT_OUT_W-1:0]  int_value;
    logic [SIG_W-1:0]             significand;
    logic                         is_negative;
    logic signed [EXP_OUT_W-1:0]  dec_exponent;
    logic                         overflow;
    logic                         last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// File: src/nll_lexer.sv
module nll_lexer (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [7:0]     char_code,
  input  logic           end_of_input,
  output nll_pkg::push_t push
);
  import nll_pkg::*;

  localparam logic [INT_BITS+4:0] INT_LIM = {6'b0, {(INT_BITS-1){1'b1}}};
  localparam logic [EXP_BITS+3:0] EXP_LIM = {5'b0, {(EXP_BITS-1){1'b1}}};
  localparam logic [EXP_BITS-1:0] EXP_MAX = {1'b0, {(EXP_BITS-1){1'b1}}};
  localparam logic [EXP_BITS-1:0] EXP_MIN = {1'b1, {(EXP_BITS-1){1'b0}}};

  function automatic logic [6:0] digit_val(input logic [7:0] c);
    logic [6:0] v;
    v = 7'd99;
    if (c >= CH_0 && c <= CH_9) begin
      v = 7'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      v = 7'(c - CH_LA) + 7'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      v = 7'(c - CH_UA) + 7'd10;
    end
    return v;
  endfunction

  lex_state_t          state, state_next;
  logic                sign_neg, sign_neg_next;
  logic [4:0]          radix, radix_next;
  logic [INT_BITS-1:0] int_acc, int_acc_next;
  logic [SIG_W-1:0]    sig_acc, sig_acc_next;
  logic [EXP_BITS-1:0] frac_count, frac_count_next;
  logic [EXP_BITS-1:0] exp_acc, exp_acc_next;
  logic                exp_neg, exp_neg_next;
  logic                ovf_flag, ovf_flag_next;
  logic                int_ovf, int_ovf_next;
  logic                halted, halted_next;

  logic       eos;
  logic [6:0] d;
  logic       c_dec, c_zero, c_oct, c_x, c_b, c_dot, c_le, c_ue;
  logic       c_plus, c_minus, c_ws;

  logic [INT_BITS+4:0]        int_scaled, int_sum;
  logic                       int_add_ovf;
  logic [63:0]                sig_sum;
  logic                       sig_sat;
  logic [SIG_W-1:0]           sig_new;
  logic [EXP_BITS+3:0]        exp_sum;
  logic                       exp_sat;
  logic [EXP_BITS-1:0]        exp_new;
  logic                       frac_sat;

  logic [INT_BITS-1:0]        int_mag;
  logic signed [INT_BITS-1:0] int_sv;
  logic signed [63:0]         int_wide;
  logic [EXP_BITS:0]          exp_ext, frac_ext, e_raw;
  logic                       e_under;
  logic signed [EXP_BITS-1:0] e_fit;
  logic signed [63:0]         e_wide;
  result_t                    int_res, flt_res, err_res, eos_res;

  lex_state_t          idle_state;
  logic                idle_sign_neg, idle_halt, idle_has;
  logic [INT_BITS-1:0] idle_int_acc;
  logic [SIG_W-1:0]    idle_sig_acc;
  result_t             idle_res;

  logic    go_idle, tok_has, fail;
  result_t tok;

  always_comb begin
    eos     = end_of_input;
    d       = eos ? 7'd99 : digit_val(char_code);
    c_dec   = !eos && char_code >= CH_0 && char_code <= CH_9;
    c_oct   = !eos && char_code >= CH_0 && char_code <= CH_7;
    c_zero  = !eos && char_code == CH_0;
    c_x     = !eos && (char_code == CH_LX || char_code == CH_UX);
    c_b     = !eos && (char_code == CH_LB || char_code == CH_UB);
    c_dot   = !eos && char_code == CH_DOT;
    c_le    = !eos && char_code == CH_LE;
    c_ue    = !eos && char_code == CH_UE;
    c_plus  = !eos && char_code == CH_PLUS;
    c_minus = !eos && char_code == CH_MINUS;
    c_ws    = !eos && (char_code == CH_SPACE || (char_code >= CH_TAB && char_code <= CH_CR));
  end

  always_comb begin
    case (radix)
      RADIX_BIN: int_scaled = (INT_BITS+5)'(int_acc) << 1;
      RADIX_OCT: int_scaled = (INT_BITS+5)'(int_acc) << 3;
      RADIX_HEX: int_scaled = (INT_BITS+5)'(int_acc) << 4;
      default:   int_scaled = ((INT_BITS+5)'(int_acc) << 3) + ((INT_BITS+5)'(int_acc) << 1);
    endcase
    int_sum     = int_scaled + (INT_BITS+5)'(d);
    int_add_ovf = int_sum > INT_LIM;

    sig_sum = (64'(sig_acc) << 3) + (64'(sig_acc) << 1) + 64'(d);
    sig_sat = sig_sum > 64'(SIG_MAX);
    sig_new = sig_sat ? SIG_MAX : sig_sum[SIG_W-1:0];

    exp_sum = ((EXP_BITS+4)'(exp_acc) << 3) + ((EXP_BITS+4)'(exp_acc) << 1)
              + (EXP_BITS+4)'(d);
    exp_sat = exp_sum > EXP_LIM;
    exp_new = exp_sat ? EXP_MAX : exp_sum[EXP_BITS-1:0];

    frac_sat = frac_count >= EXP_MAX;
  end

  always_comb begin
    int_mag  = sign_neg ? (INT_BITS'(0) - int_acc) : int_acc;
    int_sv   = int_mag;
    int_wide = 64'(int_sv);

    exp_ext  = {1'b0, exp_acc};
    frac_ext = {1'b0, frac_count};
    e_raw    = (exp_neg ? ((EXP_BITS+1)'(0) - exp_ext) : exp_ext) - frac_ext;
    e_under  = e_raw[EXP_BITS] != e_raw[EXP_BITS-1];
    e_fit    = e_under ? EXP_MIN : e_raw[EXP_BITS-1:0];
    e_wide   = 64'(e_fit);

    int_res           = '0;
    int_res.kind      = KIND_INT;
    int_res.int_value = int_wide[INT_OUT_W-1:0];
    int_res.overflow  = int_ovf;

    flt_res              = '0;
    flt_res.kind         = KIND_FLOAT;
    flt_res.significand  = sig_acc;
    flt_res.is_negative  = sign_neg;
    flt_res.dec_exponent = e_wide[EXP_OUT_W-1:0];
    flt_res.overflow     = ovf_flag | e_under;

    err_res      = '0;
    err_res.kind = KIND_ERR;
    eos_res      = '0;
    eos_res.kind = KIND_EOS;
  end

  // Scanning from the idle state always starts from a cleared token.
  always_comb begin
    idle_state    = LEX_IDLE;
    idle_sign_neg = 1'b0;
    idle_int_acc  = '0;
    idle_sig_acc  = '0;
    idle_halt     = 1'b0;
    idle_has      = 1'b0;
    idle_res      = eos_res;
    if (eos) begin
      idle_has = 1'b1;
    end else if (c_ws) begin
      idle_state = LEX_IDLE;
    end else if (c_minus) begin
      idle_sign_neg = 1'b1;
      idle_state    = LEX_SIGN;
    end else if (c_plus) begin
      idle_state = LEX_SIGN;
    end else if (c_zero) begin
      idle_state = LEX_ZERO;
    end else if (c_dec) begin
      idle_state   = LEX_DEC;
      idle_int_acc = INT_BITS'(d);
      idle_sig_acc = SIG_W'(d);
    end else begin
      idle_has  = 1'b1;
      idle_res  = err_res;
      idle_halt = 1'b1;
    end
  end

  always_comb begin
    state_next      = state;
    sign_neg_next   = sign_neg;
    radix_next      = radix;
    int_acc_next    = int_acc;
    sig_acc_next    = sig_acc;
    frac_count_next = frac_count;
    exp_acc_next    = exp_acc;
    exp_neg_next    = exp_neg;
    ovf_flag_next   = ovf_flag;
    int_ovf_next    = int_ovf;
    halted_next     = halted;
    go_idle         = 1'b0;
    tok_has         = 1'b0;
    tok             = int_res;
    fail            = 1'b0;

    if (step && !halted) begin
      case (state)
        LEX_SIGN: begin
          if (c_zero) begin
            state_next = LEX_ZERO;
          end else if (c_dec) begin
            radix_next    = RADIX_DEC;
            int_acc_next  = INT_BITS'(d);
            sig_acc_next  = SIG_W'(d);
            state_next    = LEX_DEC;
          end else begin
            fail = 1'b1;
          end
        end
        LEX_ZERO: begin
          if (c_x) begin
            radix_next = RADIX_HEX;
            state_next = LEX_RPFX;
          end else if (c_b) begin
            radix_next = RADIX_BIN;
            state_next = LEX_RPFX;
          end else if (c_oct) begin
            radix_next   = RADIX_OCT;
            int_acc_next = INT_BITS'(d);
            state_next   = LEX_RDIG;
          end else if (c_dot) begin
            state_next = LEX_FRAC0;
          end else if (c_le) begin
            state_next = LEX_EXP0;
          end else begin
            tok_has = 1'b1;
            go_idle = 1'b1;
          end
        end
        LEX_RPFX: begin
          if ({5'b0, radix} > 10'(d)) begin
            int_acc_next = int_sum[INT_BITS-1:0];
            int_ovf_next = int_ovf | int_add_ovf;
            state_next   = LEX_RDIG;
          end else begin
            fail = 1'b1;
          end
        end
        LEX_RDIG: begin
          if ({5'b0, radix} > 10'(d)) begin
            int_acc_next = int_sum[INT_BITS-1:0];
            int_ovf_next = int_ovf | int_add_ovf;
          end else begin
            tok_has = 1'b1;
            go_idle = 1'b1;
          end
        end
        LEX_DEC: begin
          if (c_dec) begin
            int_acc_next  = int_sum[INT_BITS-1:0];
            int_ovf_next  = int_ovf | int_add_ovf;
            sig_acc_next  = sig_new;
            ovf_flag_next = ovf_flag | sig_sat;
          end else if (c_dot) begin
            state_next = LEX_FRAC0;
          end else if (c_le || c_ue) begin
            state_next = LEX_EXP0;
          end else begin
            tok_has = 1'b1;
            go_idle = 1'b1;
          end
        end
        LEX_FRAC0, LEX_FRAC: begin
          if (c_dec) begin
            sig_acc_next  = sig_new;
            ovf_flag_next = ovf_flag | sig_sat | frac_sat;
            if (!frac_sat) begin
              frac_count_next = frac_count + 1'b1;
            end
            state_next = LEX_FRAC;
          end else if (state == LEX_FRAC0) begin
            fail = 1'b1;
          end else if (c_le || c_ue) begin
            state_next = LEX_EXP0;
          end else begin
            tok_has = 1'b1;
            tok     = flt_res;
            go_idle = 1'b1;
          end
        end
        LEX_EXP0: begin
          if (c_plus) begin
            state_next = LEX_EXPS;
          end else if (c_minus) begin
            exp_neg_next = 1'b1;
            state_next   = LEX_EXPS;
          end else if (c_dec) begin
            exp_acc_next  = exp_new;
            ovf_flag_next = ovf_flag | exp_sat;
            state_next    = LEX_EXPD;
          end else begin
            fail = 1'b1;
          end
        end
        LEX_EXPS, LEX_EXPD: begin
          if (c_dec) begin
            exp_acc_next  = exp_new;
            ovf_flag_next = ovf_flag | exp_sat;
            state_next    = LEX_EXPD;
          end else if (state == LEX_EXPS) begin
            fail = 1'b1;
          end else begin
            tok_has = 1'b1;
            tok     = flt_res;
            go_idle = 1'b1;
          end
        end
        default: begin
          go_idle = 1'b1;
        end
      endcase

      if (fail) begin
        state_next  = LEX_IDLE;
        halted_next = 1'b1;
      end

      if (go_idle) begin
        state_next      = idle_state;
        sign_neg_next   = idle_sign_neg;
        radix_next      = RADIX_DEC;
        int_acc_next    = idle_int_acc;
        sig_acc_next    = idle_sig_acc;
        frac_count_next = '0;
        exp_acc_next    = '0;
        exp_neg_next    = 1'b0;
        ovf_flag_next   = 1'b0;
        int_ovf_next    = 1'b0;
        halted_next     = idle_halt;
      end
    end
  end

  always_comb begin
    push = '0;
    if (fail) begin
      push.num = 2'd1;
      push.r0  = err_res;
    end else if (tok_has) begin
      push.r0 = tok;
      if (idle_has) begin
        push.num = 2'd2;
        push.r1  = idle_res;
      end else begin
        push.num = 2'd1;
      end
    end else if (go_idle && idle_has) begin
      push.num = 2'd1;
      push.r0  = idle_res;
    end
    if (push.num == 2'd2) begin
      push.r1.last = 1'b1;
    end else begin
      push.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= LEX_IDLE;
      sign_neg   <= 1'b0;
      radix      <= RADIX_DEC;
      int_acc    <= '0;
      sig_acc    <= '0;
      frac_count <= '0;
      exp_acc    <= '0;
      exp_neg    <= 1'b0;
      ovf_flag   <= 1'b0;
      int_ovf    <= 1'b0;
      halted     <= 1'b0;
    end else begin
      state      <= state_next;
      sign_neg   <= sign_neg_next;
      radix      <= radix_next;
      int_acc    <= int_acc_next;
      sig_acc    <= sig_acc_next;
      frac_count <= frac_count_next;
      exp_acc    <= exp_acc_next;
      exp_neg    <= exp_neg_next;
      ovf_flag   <= ovf_flag_next;
      int_ovf    <= int_ovf_next;
      halted     <= halted_next;
    end
  end

endmodule

// File: src/nll_res_fifo.sv
module nll_res_fifo (
  input  logic             clk,
  input  logic             rst,
  input  nll_pkg::push_t   push,
  input  logic             pop,
  output nll_pkg::result_t head,
  output logic             not_empty,
  output logic             room
);
  import nll_pkg::*;

  result_t          mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr, wr_ptr_next, wr_ptr_inc;
  logic [RQ_AW-1:0] rd_ptr, rd_ptr_next;
  logic [RQ_CW-1:0] count, count_next;

  always_comb begin
    wr_ptr_inc  = wr_ptr + 1'b1;
    wr_ptr_next = wr_ptr + RQ_AW'(push.num);
    rd_ptr_next = rd_ptr + RQ_AW'(pop);
    count_next  = count + RQ_CW'(push.num) - RQ_CW'(pop);
    head        = mem[rd_ptr];
    not_empty   = count != '0;
    room        = count <= RQ_CW'(RQ_DEPTH - 2);
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr_inc] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

// File: src/number_literal_lexer_core.sv
// Numeric literal lexer, one character per request on the input channel.
// Input channel: in_valid, in_stall, char_code, end_of_input. A request with
// end_of_input set carries no character and closes the stream.
// Output channel: out_valid, out_stall and one token per request: kind,
// int_value, significand, is_negative, dec_exponent, overflow, last. One input
// request yields zero, one or two tokens; last marks the final one.
// A character is held in the input register, the lexer step then writes the
// tokens it causes into a four-entry token queue, and each token is offered
// from the head of that queue.
// Throughput: one character per cycle while the queue has room for two
// tokens; the queue drains one token per cycle while out_stall is low.
// When the receiver stalls, the queue fills and in_stall rises once fewer
// than two entries are free; the held character is processed as soon as room
// returns. Tokens wait unchanged on the outputs while stalled.
// Reset clears the lexer to its idle state, empties the queue and holds
// in_stall high for its duration. After an error token the block accepts and
// drops every further character until the next reset.
module number_literal_lexer_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            char_code,
  input  logic                                  end_of_input,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            kind,
  output logic signed [nll_pkg::INT_OUT_W-1:0]  int_value,
  output logic [nll_pkg::SIG_W-1:0]             significand,
  output logic                                  is_negative,
  output logic signed [nll_pkg::EXP_OUT_W-1:0]  dec_exponent,
  output logic                                  overflow,
  output logic                                  last
);
  import nll_pkg::*;

  logic       in_q_valid, in_q_valid_next;
  logic [7:0] char_q;
  logic       eos_q;
  logic       step, room, not_empty, pop;
  push_t      lex_push;
  result_t    head;

  always_comb begin
    step            = in_q_valid && room;
    in_stall        = rst || (in_q_valid && !room);
    in_q_valid_next = in_stall ? in_q_valid : in_valid;
    pop             = not_empty && !out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= in_q_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      char_q <= char_code;
      eos_q  <= end_of_input;
    end
  end

  nll_lexer u_lexer (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .char_code    (char_q),
    .end_of_input (eos_q),
    .push         (lex_push)
  );

  nll_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (lex_push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  always_comb begin
    out_valid    = not_empty;
    kind         = head.kind;
    int_value    = head.int_value;
    significand  = head.significand;
    is_negative  = head.is_negative;
    dec_exponent = head.dec_exponent;
    overflow     = head.overflow;
    last         = head.last;
  end

  // A character waiting for queue room is kept until it is processed.
  assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !step |=> in_q_valid && $stable(char_q) && $stable(eos_q))
    else $error("held character lost or changed");

  // After an error token the lexer produces nothing more.
  assert property (@(posedge clk) disable iff (rst)
    (lex_push.num == 2'd1 && lex_push.r0.kind == KIND_ERR) ||
    (lex_push.num == 2'd2 && lex_push.r1.kind == KIND_ERR)
    |=> lex_push.num == 2'd0)
    else $error("token produced after an error");

  // Two tokens from one character are a finished number followed by the
  // outcome of rescanning the terminating character.
  assert property (@(posedge clk) disable iff (rst)
    lex_push.num == 2'd2 |->
      (lex_push.r0.kind == KIND_INT || lex_push.r0.kind == KIND_FLOAT) &&
      (lex_push.r1.kind == KIND_ERR || lex_push.r1.kind == KIND_EOS) &&
      !lex_push.r0.last && lex_push.r1.last)
    else $error("malformed token pair");

endmodule
